// ===== rtl/core/tasp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasp_pkg: shared types and constants of the tar archive stream parser
// Holds the parser phase encoding, byte kind codes, header field offsets and
// the transaction payload carried from the parser core to the response buffer.
// ----------------------------------------------------------------------------
package tasp_pkg;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_DATA   = 4'b0010,
      PH_PAD    = 4'b0100,
      PH_END    = 4'b1000
   } phase_type;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_DATA    = 2'd1;
   localparam logic [1:0] KIND_PAD     = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam logic [8:0] BLOCK_FIRST = 9'd0;
   localparam logic [8:0] BLOCK_LAST  = 9'd511;
   localparam logic [8:0] SIZE_FIRST  = 9'd124;
   localparam logic [8:0] SIZE_LAST   = 9'd134;
   localparam logic [8:0] MAGIC_FIRST = 9'd257;
   localparam logic [8:0] MAGIC_LAST  = 9'd261;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;

   typedef struct packed {
      logic [1:0]  byte_kind;
      logic [7:0]  byte_value;
      logic [8:0]  header_offset;
      logic [31:0] entry_size;
      logic        header_done;
      logic        archive_end;
   } rsp_type;

   // Expected character of the "ustar" magic at a position counted from its start.
   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h75;
         3'd1:    ch = 8'h73;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h61;
         3'd4:    ch = 8'h72;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] phase_kind(input phase_type ph);
      logic [1:0] k;
      unique case (ph)
         PH_HEADER: k = KIND_HEADER;
         PH_DATA:   k = KIND_DATA;
         PH_PAD:    k = KIND_PAD;
         PH_END:    k = KIND_IGNORED;
         default:   k = KIND_IGNORED;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/tar_archive_stream_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_archive_stream_parser_unit: ustar archive byte stream tagger
// Walks a ustar archive one byte per transaction and labels every byte.
// ----------------------------------------------------------------------------
// The unit takes one archive byte per clock while not stalled and returns one
// tagged result per byte, registered, in order. Each byte is labeled as
// header, file data, padding or ignored; its offset within the current
// 512-byte block is given, along with the running octal size decoded from
// header offsets 124 to 134 (wrapping at 32 bits, digits not checked). A
// header whose "ustar" magic at offsets 257 to 261 does not match, or any
// header after the first whose name starts with a zero byte, stops parsing:
// archive_end is raised on that byte and all later bytes are tagged as
// ignored until a byte arrives with start_of_archive set, which restarts the
// parser with that byte as offset 0 of the first header. header_done marks
// byte 511 of a good header. Name matching is left to downstream logic, which
// sees the header bytes with their offsets. Throughput is one byte per cycle
// when not stalled: the whole classification and the size decode (shift by
// three and one 32-bit add) fit between the parser state registers and the
// response register. A two-entry response buffer keeps the input open while
// one result waits; req_stall rises only once both entries are full.
// ----------------------------------------------------------------------------
module tar_archive_stream_parser_unit
   import tasp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_start_of_archive,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_byte_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [8:0]  rsp_header_offset,
   output logic [31:0] rsp_entry_size,
   output logic        rsp_header_done,
   output logic        rsp_archive_end
);

   logic    accept;
   logic    buf_full;
   rsp_type core_result;
   rsp_type rsp_data;

   // A transaction is taken whenever the buffer has a free entry.
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   tasp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .advance          (accept),
      .stream_byte      (req_stream_byte),
      .start_of_archive (req_start_of_archive),
      .result           (core_result)
   );

   tasp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_byte_kind     = rsp_data.byte_kind;
   assign rsp_byte_value    = rsp_data.byte_value;
   assign rsp_header_offset = rsp_data.header_offset;
   assign rsp_entry_size    = rsp_data.entry_size;
   assign rsp_header_done   = rsp_data.header_done;
   assign rsp_archive_end   = rsp_data.archive_end;

`ifndef ASSERT_OFF
   // The header-complete flag only appears on the last byte of a header block.
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_done |->
         rsp_header_offset == BLOCK_LAST && rsp_byte_kind == KIND_HEADER)
      else $error("tar parser: header_done away from header byte 511");

   // Parsing stops only on a header byte, and never on a completed header.
   a_end_in_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_archive_end |->
         rsp_byte_kind == KIND_HEADER && !rsp_header_done)
      else $error("tar parser: archive_end outside a header byte");

   // A byte taken while the output is empty shows up in the next cycle.
   a_one_cycle_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> rsp_valid)
      else $error("tar parser: accepted byte did not reach the output");
`endif

endmodule

// ===== rtl/core/tasp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasp_core: parser state and per-byte classification
// Holds the archive parsing state and computes the tagged result of one byte
// in a single pass; the state advances only when a byte is taken.
// ----------------------------------------------------------------------------
module tasp_core
   import tasp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] stream_byte,
   input  logic       start_of_archive,
   output rsp_type    result
);

   phase_type   phase_ff, phase_in;
   logic [8:0]  offset_ff, offset_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] remain_ff, remain_in;
   logic        magic_ff, magic_in;
   logic        first_ff, first_in;

   phase_type   cur_phase;
   logic [8:0]  cur_offset;
   logic [31:0] cur_size;
   logic [31:0] cur_remain;
   logic        cur_magic;
   logic        cur_first;
   logic [8:0]  magic_pos;
   logic [31:0] digit;
   logic        done;
   logic        stop;

   assign magic_pos = cur_offset - MAGIC_FIRST;
   assign digit     = {24'd0, stream_byte} - {24'd0, ASCII_ZERO};

   always_comb begin
      // A start marker puts the parser back to its reset state before this byte.
      cur_phase  = start_of_archive ? PH_HEADER   : phase_ff;
      cur_offset = start_of_archive ? BLOCK_FIRST : offset_ff;
      cur_size   = start_of_archive ? 32'd0       : size_ff;
      cur_remain = start_of_archive ? 32'd0       : remain_ff;
      cur_magic  = start_of_archive ? 1'b1        : magic_ff;
      cur_first  = start_of_archive ? 1'b1        : first_ff;

      phase_in  = cur_phase;
      size_in   = cur_size;
      remain_in = cur_remain;
      magic_in  = cur_magic;
      first_in  = cur_first;
      done      = 1'b0;
      stop      = 1'b0;

      unique case (cur_phase)
         PH_HEADER: begin
            if (cur_offset == BLOCK_FIRST) begin
               size_in  = 32'd0;
               magic_in = 1'b1;
            end
            if (cur_offset == BLOCK_FIRST && !cur_first && stream_byte == 8'd0) begin
               stop     = 1'b1;
               phase_in = PH_END;
            end else begin
               if (cur_offset >= SIZE_FIRST && cur_offset <= SIZE_LAST) begin
                  size_in = {size_in[28:0], 3'b000} + digit;
               end
               if (cur_offset >= MAGIC_FIRST && cur_offset <= MAGIC_LAST) begin
                  if (stream_byte != magic_char(magic_pos[2:0])) begin
                     magic_in = 1'b0;
                  end
                  if (cur_offset == MAGIC_LAST && !magic_in) begin
                     stop     = 1'b1;
                     phase_in = PH_END;
                  end
               end
               if (cur_offset == BLOCK_LAST) begin
                  done      = 1'b1;
                  first_in  = 1'b0;
                  remain_in = size_in;
                  phase_in  = (size_in != 32'd0) ? PH_DATA : PH_HEADER;
               end
            end
         end
         PH_DATA: begin
            remain_in = cur_remain - 32'd1;
            if (remain_in == 32'd0) begin
               phase_in = (cur_offset != BLOCK_LAST) ? PH_PAD : PH_HEADER;
            end
         end
         PH_PAD: begin
            if (cur_offset == BLOCK_LAST) begin
               phase_in = PH_HEADER;
            end
         end
         PH_END: begin
            phase_in = PH_END;
         end
         default: begin
            phase_in = PH_END;
         end
      endcase

      offset_in = cur_offset + 9'd1;
   end

   always_comb begin
      result.byte_kind     = phase_kind(cur_phase);
      result.byte_value    = stream_byte;
      result.header_offset = cur_offset;
      result.entry_size    = size_in;
      result.header_done   = done;
      result.archive_end   = stop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         offset_ff <= BLOCK_FIRST;
         size_ff   <= 32'd0;
         remain_ff <= 32'd0;
         magic_ff  <= 1'b1;
         first_ff  <= 1'b1;
      end else if (advance) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         size_ff   <= size_in;
         remain_ff <= remain_in;
         magic_ff  <= magic_in;
         first_ff  <= first_in;
      end
   end

`ifndef ASSERT_OFF
   // The data phase is only entered or kept with bytes still owed.
   a_data_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remain_ff != 32'd0)
      else $error("tasp_core: data phase with no bytes remaining");
`endif

endmodule

// ===== rtl/core/tasp_rsp_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasp_rsp_buf: response register with skid stage
// Holds results until the consumer takes them; a second entry absorbs the
// transaction that arrives in the cycle a stall is first seen.
// ----------------------------------------------------------------------------
module tasp_rsp_buf
   import tasp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
